[hdl/rlcm_pkg.sv]
package rlcm_pkg;

    localparam int Lanes          = 4;
    localparam int LaneW          = 8;
    localparam int Half           = Lanes / 2;
    localparam int Pairs          = Lanes / 2;
    localparam int CntW           = $clog2(Pairs + 1);
    localparam int MismatchW      = 14;
    localparam int BufferDepthDef = 4096;

    localparam logic [MismatchW-1:0] MismatchMax = 14'd8192;

    typedef enum logic [0:0] {
        CfgFaultTol   = 1'b0,
        CfgSecondPass = 1'b1
    } t_cfg_idx;

    typedef logic [Lanes-1:0][LaneW-1:0] t_vec;

    typedef struct packed {
        logic signed [LaneW-1:0] lane0_in;
        logic signed [LaneW-1:0] lane1_in;
        logic signed [LaneW-1:0] lane2_in;
        logic signed [LaneW-1:0] lane3_in;
        logic                    last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [LaneW-1:0] lane0_out;
        logic signed [LaneW-1:0] lane1_out;
        logic signed [LaneW-1:0] lane2_out;
        logic signed [LaneW-1:0] lane3_out;
        logic                    data_valid;
        logic [MismatchW-1:0]    mismatch_count;
        logic                    frame_done;
    } t_out_word;

    typedef struct packed {
        logic fault_tol;
        logic second_pass;
    } t_mode;

endpackage

[hdl/rlcm_buffer.sv]
module rlcm_buffer #(
    parameter int DEPTH = rlcm_pkg::BufferDepthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output rlcm_pkg::t_vec            o_rd_data,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  rlcm_pkg::t_vec            i_wr_data
);
    import rlcm_pkg::*;

    t_vec r_mem [DEPTH];
    t_vec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/rlcm_merge.sv]
module rlcm_merge (
    input  rlcm_pkg::t_vec             i_lanes,
    input  rlcm_pkg::t_vec             i_buf,
    input  rlcm_pkg::t_mode            i_mode,
    output rlcm_pkg::t_vec             o_vec,
    output logic                       o_data_valid,
    output logic [rlcm_pkg::CntW-1:0]  o_mismatches
);
    import rlcm_pkg::*;

    always_comb begin
        o_mismatches = '0;
        o_vec        = i_lanes;
        o_data_valid = 1'b1;
        if (i_mode.fault_tol) begin
            for (int p = 0; p < Pairs; p++) begin
                if (i_lanes[2*p] != i_lanes[2*p+1]) begin
                    o_mismatches = o_mismatches + CntW'(1);
                end
            end
            for (int c = 0; c < Lanes; c++) begin
                if (c < Half) begin
                    o_vec[c] = i_mode.second_pass ? i_buf[c] : i_lanes[2*c];
                end else begin
                    o_vec[c] = i_mode.second_pass ? i_lanes[2*(c-Half)] : '0;
                end
            end
            o_data_valid = i_mode.second_pass;
        end
    end

endmodule

[hdl/redundant_lane_compare_merge.sv]
// Stage 1 registers each accepted word, the output register its result, if any.
// Throughput: one word per cycle unless output stalls; buffer read, merge and
// write-back are one registered pass with neighbor write-to-read forwarding.
// Reset (synchronous, active low) clears both config registers, the frame
// position, the mismatch total and all valid flags; buffer contents are kept.
module redundant_lane_compare_merge #(
    parameter int BUFFER_DEPTH = rlcm_pkg::BufferDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  rlcm_pkg::t_cfg_idx  i_cfg_index,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rlcm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rlcm_pkg::t_out_word o_out_word
);
    import rlcm_pkg::*;

    localparam int PosW = $clog2(BUFFER_DEPTH);
    localparam logic [PosW-1:0] PosLast = PosW'(BUFFER_DEPTH - 1);

    t_mode                r_mode;
    logic [PosW-1:0]      r_pos;
    logic [MismatchW-1:0] r_total;
    logic                 r_s1_valid;
    t_vec                 r_s1_lanes;
    logic                 r_s1_last;
    logic [PosW-1:0]      r_s1_pos;
    logic                 r_fwd;
    t_vec                 r_fwd_vec;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 in_acc;
    logic                 s1_adv;
    logic                 has_res;
    t_vec                 in_vec;
    t_vec                 buf_rd;
    t_vec                 s1_buf;
    t_vec                 vec;
    logic                 data_valid;
    logic [CntW-1:0]      mismatches;
    logic [MismatchW-1:0] sum;
    logic [MismatchW-1:0] n_total;
    t_out_word            n_out_word;

    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready  = ~r_s1_valid | s1_adv;
    assign in_acc      = i_in_valid & o_in_ready;

    assign in_vec[0] = i_in_word.lane0_in;
    assign in_vec[1] = i_in_word.lane1_in;
    assign in_vec[2] = i_in_word.lane2_in;
    assign in_vec[3] = i_in_word.lane3_in;

    rlcm_buffer #(
        .DEPTH(BUFFER_DEPTH)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_pos),
        .o_rd_data (buf_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (vec)
    );

    assign s1_buf = r_fwd ? r_fwd_vec : buf_rd;

    rlcm_merge u_merge (
        .i_lanes      (r_s1_lanes),
        .i_buf        (s1_buf),
        .i_mode       (r_mode),
        .o_vec        (vec),
        .o_data_valid (data_valid),
        .o_mismatches (mismatches)
    );

    assign sum     = r_total + MismatchW'(mismatches);
    assign n_total = (sum > MismatchMax) ? MismatchMax : sum;
    assign has_res = data_valid | r_s1_last;

    always_comb begin
        n_out_word.lane0_out      = data_valid ? vec[0] : '0;
        n_out_word.lane1_out      = data_valid ? vec[1] : '0;
        n_out_word.lane2_out      = data_valid ? vec[2] : '0;
        n_out_word.lane3_out      = data_valid ? vec[3] : '0;
        n_out_word.data_valid     = data_valid;
        n_out_word.mismatch_count = r_s1_last ? n_total : '0;
        n_out_word.frame_done     = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgFaultTol:   r_mode.fault_tol   <= i_cfg_data;
                    CfgSecondPass: r_mode.second_pass <= i_cfg_data;
                    default:       r_mode             <= r_mode;
                endcase
            end
            if (in_acc) begin
                r_pos <= (i_in_word.last_in || r_pos == PosLast) ? '0 : r_pos + PosW'(1);
                r_fwd <= s1_adv && (r_s1_pos == r_pos);
            end
            if (s1_adv) begin
                r_total <= r_s1_last ? '0 : n_total;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= has_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_lanes <= in_vec;
            r_s1_last  <= i_in_word.last_in;
            r_s1_pos   <= r_pos;
            r_fwd_vec  <= vec;
        end
        if (s1_adv && has_res) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
